FILE: hdl/cas_pkg.sv
package cas_pkg;

  // request kinds carried in the low bits of the input word
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  // configuration register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_GENERATIONS    = 2'd2,
    REG_WALL_THRESHOLD = 2'd3
  } reg_index_t;

  localparam logic [8:0] GRID_WIDTH_RESET     = 9'd150;
  localparam logic [6:0] GRID_HEIGHT_RESET    = 7'd50;
  localparam logic [7:0] GENERATIONS_RESET    = 8'd100;
  localparam logic [3:0] WALL_THRESHOLD_RESET = 4'd4;

  typedef struct packed {
    logic       start;
    logic [7:0] generations;
    logic [3:0] threshold;
  } run_ctl_t;

  typedef struct packed {
    logic busy;
    logic pass_end;
    logic done;
  } pass_stat_t;

endpackage

FILE: hdl/cas_store.sv
module cas_store
  import cas_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic          re,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_bit;
    end
    if (re) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/cas_pass.sv
module cas_pass
  import cas_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  run_ctl_t                               ctl,
  input  logic [$clog2(MAX_WIDTH):0]             eff_w,
  input  logic [$clog2(MAX_HEIGHT):0]            eff_h,
  input  logic                                   src_bit,
  output logic                                   rd_re,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] rd_addr,
  output logic                                   wr_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] wr_addr,
  output logic                                   wr_bit,
  output pass_stat_t                             stat
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  typedef enum logic [1:0] {
    E_IDLE,
    E_START,
    E_COL,
    E_END
  } eng_state_t;

  eng_state_t  state;
  logic [HW-1:0] y;
  logic [CW:0]   fx;
  logic [1:0]    ph;
  logic [7:0]    gen_left;
  logic [3:0]    thr;
  logic [2:0]    win_m;
  logic [2:0]    win_r;
  logic          b0;
  logic          b1;
  logic          oob_q;

  logic [31:0] rd_row;
  logic [31:0] rd_addr32;
  logic [31:0] wr_addr32;
  logic        cap_bit;
  logic [2:0]  new_col;
  logic [3:0]  wall_count;
  logic        empty_grid;
  logic        last_row;

  // row of this phase's read: y-1, y, y+1 (wraps huge when y-1 < 0)
  assign rd_row     = 32'(y) + 32'(ph) - 32'd1;
  assign rd_addr32  = rd_row * 32'(MAX_WIDTH) + 32'(fx);
  assign rd_addr    = rd_addr32[AW-1:0];
  assign rd_re      = (state == E_COL) && (ph != 2'd3) &&
                      (rd_row < 32'(eff_h)) && (fx < eff_w);
  assign wr_addr32  = 32'(y) * 32'(MAX_WIDTH) + 32'(fx) - 32'd1;
  assign wr_addr    = wr_addr32[AW-1:0];

  // cells outside the grid count as walls
  assign cap_bit    = oob_q | src_bit;
  assign new_col    = {cap_bit, b1, b0};
  assign wall_count = 4'($countones({win_m, win_r, new_col}));
  assign wr_bit     = wall_count > thr;
  assign wr_we      = (state == E_COL) && (ph == 2'd3) && (fx != '0);

  assign empty_grid = (eff_w == '0) || (eff_h == '0);
  assign last_row   = ((HW+1)'(y) + (HW+1)'(1)) == eff_h;

  assign stat.busy     = state != E_IDLE;
  assign stat.pass_end = state == E_END;
  assign stat.done     = (state == E_END) && (gen_left == 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      y        <= '0;
      fx       <= '0;
      ph       <= '0;
      gen_left <= '0;
    end else begin
      oob_q <= !rd_re;
      case (state)
        E_IDLE: begin
          if (ctl.start) begin
            gen_left <= ctl.generations;
            thr      <= ctl.threshold;
            state    <= E_START;
          end
        end
        E_START: begin
          y     <= '0;
          fx    <= '0;
          ph    <= '0;
          win_r <= 3'b111;
          state <= empty_grid ? E_END : E_COL;
        end
        E_COL: begin
          ph <= ph + 2'd1;
          case (ph)
            2'd1: b0 <= cap_bit;
            2'd2: b1 <= cap_bit;
            2'd3: begin
              // shift the window one column right
              win_m <= win_r;
              win_r <= new_col;
              if (fx == eff_w) begin
                fx    <= '0;
                win_r <= 3'b111;
                if (last_row) begin
                  state <= E_END;
                end else begin
                  y <= y + HW'(1);
                end
              end else begin
                fx <= fx + (CW+1)'(1);
              end
            end
            default: ;
          endcase
        end
        E_END: begin
          gen_left <= gen_left - 8'd1;
          state    <= (gen_left == 8'd1) ? E_IDLE : E_START;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/cave_automaton_smoother_core.sv
// Cave grid smoother. Software loads a wall/floor grid one cell per word
// (write), reads cells back (read), and issues a run word that applies
// the configured number of 3x3 wall-threshold generations; cells beyond the
// grid in use count as walls. Writes and reads are taken one per clock
// while the output side is not stalled. A run holds the input side until
// it is done and then returns one result word. A run is paced by the
// single read port of the source store: each column of the sliding window
// costs three reads and one shift step. Addresses outside the grid return
// status 1 and are not written.
module cave_automaton_smoother_core
  import cas_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // req_type[1:0], row[7:2], col[15:8], wall_in[16], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // wall_out[0], status[1], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [8:0] grid_width;
  logic [6:0] grid_height;
  logic [7:0] generations;
  logic [3:0] wall_threshold;

  logic       cur_sel;
  logic       p_valid;
  logic       p_wait;
  logic       p_rd;
  logic       p_st;
  logic       out_valid;
  logic       out_wall;
  logic       out_st;

  logic [31:0]   eff_w32;
  logic [31:0]   eff_h32;
  logic [CW:0]   eff_w;
  logic [HW:0]   eff_h;
  req_type_t     req;
  logic [5:0]    req_row;
  logic [7:0]    req_col;
  logic          req_wall;
  logic          req_oob;
  logic [31:0]   req_addr32;
  logic          acc;
  logic          p_move;
  logic          req_we;
  logic          req_re;
  run_ctl_t      ctl;
  pass_stat_t    stat;
  logic          eng_re;
  logic [AW-1:0] eng_ra;
  logic          eng_we;
  logic [AW-1:0] eng_wa;
  logic          eng_bit;
  logic [AW-1:0] rd_addr;
  logic          rd_a;
  logic          rd_b;
  logic          cur_bit;
  logic          we_a;
  logic          we_b;
  logic [AW-1:0] wa_a;
  logic [AW-1:0] wa_b;
  logic          wd_a;
  logic          wd_b;
  logic          cfg_wr;

  // clamp dimensions to the store size
  assign eff_w32 = (32'(grid_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(grid_width);
  assign eff_h32 = (32'(grid_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(grid_height);
  assign eff_w   = eff_w32[CW:0];
  assign eff_h   = eff_h32[HW:0];

  assign req      = req_type_t'(s_tdata[1:0]);
  assign req_row  = s_tdata[7:2];
  assign req_col  = s_tdata[15:8];
  assign req_wall = s_tdata[16];
  assign req_oob  = (32'(req_row) >= eff_h32) || (32'(req_col) >= eff_w32);
  assign req_addr32 = 32'(req_row) * 32'(MAX_WIDTH) + 32'(req_col);

  assign p_move   = p_valid && !p_wait && (!out_valid || m_tready);
  assign s_tready = !p_valid || p_move;
  assign acc      = s_tvalid && s_tready;
  assign req_we   = acc && (req == REQ_WRITE) && !req_oob;
  assign req_re   = acc && (req == REQ_READ) && !req_oob;

  assign ctl.start       = acc && (req == REQ_RUN) && (generations != 8'd0);
  assign ctl.generations = generations;
  assign ctl.threshold   = wall_threshold;

  // the pass engine reads the current store and writes the other one
  assign rd_addr = stat.busy ? eng_ra : req_addr32[AW-1:0];
  assign cur_bit = cur_sel ? rd_b : rd_a;
  assign we_a    = cur_sel ? eng_we : req_we;
  assign we_b    = cur_sel ? req_we : eng_we;
  assign wa_a    = cur_sel ? eng_wa : req_addr32[AW-1:0];
  assign wa_b    = cur_sel ? req_addr32[AW-1:0] : eng_wa;
  assign wd_a    = cur_sel ? eng_bit : req_wall;
  assign wd_b    = cur_sel ? req_wall : eng_bit;

  cas_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk     (clk),
    .we      (we_a),
    .wr_addr (wa_a),
    .wr_bit  (wd_a),
    .re      (eng_re | req_re),
    .rd_addr (rd_addr),
    .rd_bit  (rd_a)
  );

  cas_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk     (clk),
    .we      (we_b),
    .wr_addr (wa_b),
    .wr_bit  (wd_b),
    .re      (eng_re | req_re),
    .rd_addr (rd_addr),
    .rd_bit  (rd_b)
  );

  cas_pass #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pass (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .src_bit (cur_bit),
    .rd_re   (eng_re),
    .rd_addr (eng_ra),
    .wr_we   (eng_we),
    .wr_addr (eng_wa),
    .wr_bit  (eng_bit),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sel   <= 1'b0;
      p_valid   <= 1'b0;
      p_wait    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stat.pass_end) begin
        cur_sel <= !cur_sel;
      end
      if (stat.done) begin
        p_wait <= 1'b0;
      end
      if (acc) begin
        p_valid <= 1'b1;
        p_wait  <= ctl.start;
        p_rd    <= req_re;
        p_st    <= ((req == REQ_WRITE) || (req == REQ_READ)) && req_oob;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      // hold the result word until taken
      if (p_move) begin
        out_valid <= 1'b1;
        out_wall  <= p_rd & cur_bit;
        out_st    <= p_st;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_st, out_wall};

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= GRID_WIDTH_RESET;
      grid_height    <= GRID_HEIGHT_RESET;
      generations    <= GENERATIONS_RESET;
      wall_threshold <= WALL_THRESHOLD_RESET;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[3:2]))
        REG_GRID_WIDTH:     grid_width     <= pwdata[8:0];
        REG_GRID_HEIGHT:    grid_height    <= pwdata[6:0];
        REG_GENERATIONS:    generations    <= pwdata[7:0];
        REG_WALL_THRESHOLD: wall_threshold <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_GRID_WIDTH:     prdata = {23'd0, grid_width};
      REG_GRID_HEIGHT:    prdata = {25'd0, grid_height};
      REG_GENERATIONS:    prdata = {24'd0, generations};
      REG_WALL_THRESHOLD: prdata = {28'd0, wall_threshold};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
